@@ rtl/spq_pkg.sv @@
// spq_pkg: request, response and entry types plus opcode and status codes
// for the sorted priority queue; no dependencies
`default_nettype none

package spq_pkg;

  localparam logic [1:0] OP_INSERT  = 2'd0;
  localparam logic [1:0] OP_DEQUEUE = 2'd1;
  localparam logic [1:0] OP_PEEK    = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic        [1:0]  opcode;
    logic signed [31:0] item_value;
    logic signed [15:0] item_priority;
  } req_t;

  typedef struct packed {
    logic signed [31:0] head_value;
    logic        [1:0]  status;
    logic        [4:0]  occupancy;
  } rsp_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic signed [15:0] prio;
  } entry_t;

  // shift commands broadcast to every cell
  typedef struct packed {
    logic insert;
    logic remove;
  } cell_cmd_t;

endpackage

`default_nettype wire

@@ rtl/sorted_priority_queue.sv @@
// sorted_priority_queue: one request accepted per cycle while req_stall is low, the
// response is registered and appears in the cycle after acceptance
// every slot of the cell chain updates in the same cycle, so inserts and
// removals run back to back; throughput is set by the response register
// reset clears the entry count and the response valid and stalls requests;
// slot contents are left as they are and never read before being written
`default_nettype none

module sorted_priority_queue #(
  parameter int CAPACITY = 16
) (
  input  wire            clk,
  input  wire            rst,
  input  wire            req_valid,
  output logic           req_stall,
  input  spq_pkg::req_t  req,
  output logic           rsp_valid,
  input  wire            rsp_stall,
  output spq_pkg::rsp_t  rsp
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]        count;
  logic [CW-1:0]        count_next;
  logic                 fire;
  logic                 full;
  logic                 empty;
  spq_pkg::cell_cmd_t   cmd;
  spq_pkg::rsp_t        rsp_next;
  spq_pkg::entry_t      new_entry;
  spq_pkg::entry_t      entries [CAPACITY];
  logic [CAPACITY-1:0]  keeps;

  // request handshake: stall during reset and while a response is held
  assign req_stall = rst || (rsp_valid && rsp_stall);
  assign fire      = req_valid && !req_stall;
  assign full      = (count == CW'(CAPACITY));
  assign empty     = (count == '0);

  assign new_entry.value = req.item_value;
  assign new_entry.prio  = req.item_priority;

  // opcode decode, count update and response word
  always_comb begin
    cmd                 = '0;
    count_next          = count;
    rsp_next.head_value = '0;
    rsp_next.status     = spq_pkg::ST_OK;
    unique case (req.opcode)
      spq_pkg::OP_INSERT: begin
        if (full) begin
          rsp_next.status = spq_pkg::ST_FULL;
        end else begin
          cmd.insert = fire;
          count_next = count + CW'(1);
        end
      end
      spq_pkg::OP_DEQUEUE: begin
        if (empty) begin
          rsp_next.status = spq_pkg::ST_EMPTY;
        end else begin
          cmd.remove          = fire;
          count_next          = count - CW'(1);
          rsp_next.head_value = entries[0].value;
        end
      end
      spq_pkg::OP_PEEK: begin
        if (empty) begin
          rsp_next.status = spq_pkg::ST_EMPTY;
        end else begin
          rsp_next.head_value = entries[0].value;
        end
      end
      default: begin
      end
    endcase
    rsp_next.occupancy = 5'(count_next);
  end

  // chain of slots
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic            occupied;
    logic            left_keep;
    spq_pkg::entry_t left_entry;
    spq_pkg::entry_t right_entry;

    assign occupied = (count > CW'(i));

    if (i == 0) begin : g_first
      assign left_keep  = 1'b1;
      assign left_entry = new_entry;
    end else begin : g_rest
      assign left_keep  = keeps[i-1];
      assign left_entry = entries[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_entry = entries[i];
    end else begin : g_inner
      assign right_entry = entries[i+1];
    end

    spq_cell #(
      .IS_HEAD (i == 0)
    ) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .new_entry   (new_entry),
      .occupied    (occupied),
      .left_keep   (left_keep),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .entry       (entries[i]),
      .keep        (keeps[i])
    );
  end

  // entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (fire) begin
      count <= count_next;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fire) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp <= rsp_next;
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_fire_rsp: assert property (@(posedge clk) disable iff (rst)
    fire |=> rsp_valid)
    else $error("accepted request produced no response");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    (fire && req.opcode == spq_pkg::OP_INSERT && !full) |=>
      count == $past(count) + CW'(1))
    else $error("insert did not grow the queue");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (fire && full && req.opcode == spq_pkg::OP_INSERT) |=>
      (rsp.status == spq_pkg::ST_FULL && $stable(count)))
    else $error("insert into full queue not rejected");

  // slots that keep their entry form an unbroken run from the head while a request is valid
  a_keep_prefix: assert property (@(posedge clk) disable iff (rst)
    req_valid |-> ((keeps & (keeps + CAPACITY'(1))) == '0))
    else $error("kept slots not contiguous from the head");

endmodule

`default_nettype wire

@@ rtl/spq_cell.sv @@
// spq_cell: one slot of the sorted chain; holds an entry and shifts it
// toward the tail on insert or toward the head on removal; uses spq_pkg
`default_nettype none

module spq_cell #(
  parameter bit IS_HEAD = 1'b0
) (
  input  wire                 clk,
  input  spq_pkg::cell_cmd_t  cmd,
  input  spq_pkg::entry_t     new_entry,
  input  wire                 occupied,
  input  wire                 left_keep,
  input  spq_pkg::entry_t     left_entry,
  input  spq_pkg::entry_t     right_entry,
  output spq_pkg::entry_t     entry,
  output logic                keep
);

  // entry stays in place when it outranks the new one; the head also keeps
  // its place on an equal priority
  always_comb begin
    keep = occupied && ((entry.prio > new_entry.prio) ||
                        (IS_HEAD && (entry.prio == new_entry.prio)));
  end

  // slot register
  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      if (!keep) begin
        if (left_keep) begin
          entry <= new_entry;
        end else begin
          entry <= left_entry;
        end
      end
    end else if (cmd.remove) begin
      entry <= right_entry;
    end
  end

endmodule

`default_nettype wire
